/* rtl/dspq_pkg.sv */
// shared types, constants and index helpers for the dedup sorted priority queue
package dspq_pkg;

   localparam int OPEN_DEPTH    = 64;
   localparam int VISITED_DEPTH = 256;
   localparam int OPEN_AW       = $clog2(OPEN_DEPTH);
   localparam int OPEN_CW       = $clog2(OPEN_DEPTH + 1);
   localparam int VIS_AW        = $clog2(VISITED_DEPTH);
   localparam int VIS_CW        = $clog2(VISITED_DEPTH + 1);
   localparam int KEY_W         = 32;
   localparam int COST_W        = 16;
   localparam int ENTRY_W       = KEY_W + COST_W;

   typedef enum logic {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      ST_POPPED       = 3'd0,
      ST_EMPTY        = 3'd1,
      ST_PUSHED       = 3'd2,
      ST_DUP          = 3'd3,
      ST_OPEN_FULL    = 3'd4,
      ST_VISITED_FULL = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_V_RD,
      S_V_CHK,
      S_O_RD,
      S_O_CHK,
      S_I_RD,
      S_I_CHK,
      S_P_CHK,
      S_RESP
   } fsm_type;

   typedef struct packed {
      logic       latch;
      logic       scan_init;
      logic       v_adv;
      logic       o_adv;
      logic       ins_rd;
      logic       ins_shift;
      logic       ins_put;
      logic       pop_rd;
      logic       pop_commit;
      logic       set_res;
      status_type code;
      logic       load_rsp;
   } cmd_type;

   typedef struct packed {
      logic is_pop;
      logic v_done;
      logic v_match;
      logic o_done;
      logic o_match;
      logic open_full;
      logic open_empty;
      logic vis_full;
      logic ins_front;
      logic ins_stop;
      logic rsp_free;
   } stat_type;

   function automatic logic [OPEN_AW-1:0] open_next(input logic [OPEN_AW-1:0] idx);
      return (idx == OPEN_AW'(OPEN_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   function automatic logic [OPEN_AW-1:0] open_prev(input logic [OPEN_AW-1:0] idx);
      return (idx == '0) ? OPEN_AW'(OPEN_DEPTH - 1) : idx - 1'b1;
   endfunction

endpackage

/* rtl/dedup_sorted_priority_queue.sv */
// top level of the dedup sorted priority queue
// Open and closed list of a best-first search.
// Request channel (req_valid/req_ready): req_command selects push (0) or
// pop (1); req_state_key and req_state_cost carry the state on a push.
// Response channel (rsp_valid/rsp_ready): one transaction per request with
// rsp_status, and rsp_out_key/rsp_out_cost for a popped state (zero else).
// A push is checked against the visited set and the open list, one stored
// key at a time, then inserted into a ring buffer in cost order by moving
// larger-cost entries up one slot at a time. A duplicate ends the scan at
// its match. The scans are paced by the single read port of each memory.
// Requests are taken only while no other request is in work; a finished
// result sits in the output register, so the next request may be taken
// while it waits for rsp_ready. A stalled receiver holds the block once a
// second result is ready. Reset empties the open list and visited set at
// once through their counts; no clearing pass is needed.
module dedup_sorted_priority_queue import dspq_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_command,
   input  logic [KEY_W-1:0]  req_state_key,
   input  logic [COST_W-1:0] req_state_cost,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [KEY_W-1:0]  rsp_out_key,
   output logic [COST_W-1:0] rsp_out_cost
);

   cmd_type  cmd;
   stat_type stat;

   dspq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dspq_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_command    (req_command),
      .req_state_key  (req_state_key),
      .req_state_cost (req_state_cost),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_cost   (rsp_out_cost)
   );

endmodule

/* rtl/dspq_ram.sv */
// generic single write port ram with registered read
module dspq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/dspq_ctrl.sv */
// controller state machine sequencing scans, insertion and pop
module dspq_ctrl import dspq_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   fsm_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.code  = ST_POPPED;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.scan_init = 1'b1;
            if (stat.is_pop) begin
               if (stat.open_empty) begin
                  cmd.set_res = 1'b1;
                  cmd.code    = ST_EMPTY;
                  state_in    = S_RESP;
               end else if (stat.vis_full) begin
                  cmd.set_res = 1'b1;
                  cmd.code    = ST_VISITED_FULL;
                  state_in    = S_RESP;
               end else begin
                  cmd.pop_rd = 1'b1;
                  state_in   = S_P_CHK;
               end
            end else begin
               state_in = S_V_RD;
            end
         end
         S_V_RD: begin
            state_in = stat.v_done ? S_O_RD : S_V_CHK;
         end
         S_V_CHK: begin
            if (stat.v_match) begin
               cmd.set_res = 1'b1;
               cmd.code    = ST_DUP;
               state_in    = S_RESP;
            end else begin
               cmd.v_adv = 1'b1;
               state_in  = S_V_RD;
            end
         end
         S_O_RD: begin
            if (!stat.o_done) begin
               state_in = S_O_CHK;
            end else if (stat.open_full) begin
               cmd.set_res = 1'b1;
               cmd.code    = ST_OPEN_FULL;
               state_in    = S_RESP;
            end else begin
               state_in = S_I_RD;
            end
         end
         S_O_CHK: begin
            if (stat.o_match) begin
               cmd.set_res = 1'b1;
               cmd.code    = ST_DUP;
               state_in    = S_RESP;
            end else begin
               cmd.o_adv = 1'b1;
               state_in  = S_O_RD;
            end
         end
         S_I_RD: begin
            if (stat.ins_front) begin
               cmd.ins_put = 1'b1;
               cmd.set_res = 1'b1;
               cmd.code    = ST_PUSHED;
               state_in    = S_RESP;
            end else begin
               cmd.ins_rd = 1'b1;
               state_in   = S_I_CHK;
            end
         end
         S_I_CHK: begin
            if (stat.ins_stop) begin
               cmd.ins_put = 1'b1;
               cmd.set_res = 1'b1;
               cmd.code    = ST_PUSHED;
               state_in    = S_RESP;
            end else begin
               cmd.ins_shift = 1'b1;
               state_in      = S_I_RD;
            end
         end
         S_P_CHK: begin
            cmd.pop_commit = 1'b1;
            cmd.set_res    = 1'b1;
            cmd.code       = ST_POPPED;
            state_in       = S_RESP;
         end
         S_RESP: begin
            if (stat.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* rtl/dspq_dp.sv */
// datapath: open list ring buffer, visited set, counters and result register
module dspq_dp import dspq_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                req_command,
   input  logic [KEY_W-1:0]    req_state_key,
   input  logic [COST_W-1:0]   req_state_cost,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [KEY_W-1:0]    rsp_out_key,
   output logic [COST_W-1:0]   rsp_out_cost
);

   logic                command_ff;
   logic [KEY_W-1:0]    key_ff;
   logic [COST_W-1:0]   cost_ff;
   logic [OPEN_AW-1:0]  head_ff, head_in;
   logic [OPEN_CW-1:0]  ocount_ff, ocount_in;
   logic [VIS_CW-1:0]   vcount_ff, vcount_in;
   logic [VIS_CW-1:0]   vidx_ff, vidx_in;
   logic [OPEN_CW-1:0]  oidx_ff, oidx_in;
   logic [OPEN_AW-1:0]  ophys_ff, ophys_in;
   status_type          res_status_ff;
   logic [KEY_W-1:0]    res_key_ff;
   logic [COST_W-1:0]   res_cost_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [COST_W-1:0]   rsp_cost_ff;

   logic [OPEN_AW-1:0]  o_rd_addr;
   logic [ENTRY_W-1:0]  o_rd_data;
   logic                o_we;
   logic [ENTRY_W-1:0]  o_wr_data;
   logic [KEY_W-1:0]    v_rd_data;
   logic [KEY_W-1:0]    o_rd_key;
   logic [COST_W-1:0]   o_rd_cost;

   assign o_rd_key  = o_rd_data[ENTRY_W-1:COST_W];
   assign o_rd_cost = o_rd_data[COST_W-1:0];

   always_comb begin
      if (cmd.pop_rd) begin
         o_rd_addr = head_ff;
      end else if (cmd.ins_rd) begin
         o_rd_addr = open_prev(ophys_ff);
      end else begin
         o_rd_addr = ophys_ff;
      end
   end

   assign o_we      = cmd.ins_put | cmd.ins_shift;
   assign o_wr_data = cmd.ins_put ? {key_ff, cost_ff} : o_rd_data;

   dspq_ram #(.WIDTH(ENTRY_W), .DEPTH(OPEN_DEPTH)) u_open_ram (
      .clock   (clock),
      .wr_en   (o_we),
      .wr_addr (ophys_ff),
      .wr_data (o_wr_data),
      .rd_addr (o_rd_addr),
      .rd_data (o_rd_data)
   );

   dspq_ram #(.WIDTH(KEY_W), .DEPTH(VISITED_DEPTH)) u_visited_ram (
      .clock   (clock),
      .wr_en   (cmd.pop_commit),
      .wr_addr (vcount_ff[VIS_AW-1:0]),
      .wr_data (o_rd_key),
      .rd_addr (vidx_ff[VIS_AW-1:0]),
      .rd_data (v_rd_data)
   );

   // counters and pointers
   always_comb begin
      head_in   = head_ff;
      ocount_in = ocount_ff;
      vcount_in = vcount_ff;
      vidx_in   = vidx_ff;
      oidx_in   = oidx_ff;
      ophys_in  = ophys_ff;
      if (cmd.scan_init) begin
         vidx_in  = '0;
         oidx_in  = '0;
         ophys_in = head_ff;
      end
      if (cmd.v_adv) begin
         vidx_in = vidx_ff + 1'b1;
      end
      if (cmd.o_adv) begin
         oidx_in  = oidx_ff + 1'b1;
         ophys_in = open_next(ophys_ff);
      end
      if (cmd.ins_shift) begin
         oidx_in  = oidx_ff - 1'b1;
         ophys_in = open_prev(ophys_ff);
      end
      if (cmd.ins_put) begin
         ocount_in = ocount_ff + 1'b1;
      end
      if (cmd.pop_commit) begin
         head_in   = open_next(head_ff);
         ocount_in = ocount_ff - 1'b1;
         vcount_in = vcount_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff   <= '0;
         ocount_ff <= '0;
         vcount_ff <= '0;
      end else begin
         head_ff   <= head_in;
         ocount_ff <= ocount_in;
         vcount_ff <= vcount_in;
      end
   end

   always_ff @(posedge clock) begin
      vidx_ff  <= vidx_in;
      oidx_ff  <= oidx_in;
      ophys_ff <= ophys_in;
      if (cmd.latch) begin
         command_ff <= req_command;
         key_ff     <= req_state_key;
         cost_ff    <= req_state_cost;
      end
      if (cmd.set_res) begin
         res_status_ff <= cmd.code;
         res_key_ff    <= cmd.pop_commit ? o_rd_key : '0;
         res_cost_ff   <= cmd.pop_commit ? o_rd_cost : '0;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_key_ff    <= res_key_ff;
         rsp_cost_ff   <= res_cost_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign stat.is_pop     = (command_ff == CMD_POP);
   assign stat.v_done     = (vidx_ff == vcount_ff);
   assign stat.v_match    = (v_rd_data == key_ff);
   assign stat.o_done     = (oidx_ff == ocount_ff);
   assign stat.o_match    = (o_rd_key == key_ff);
   assign stat.open_full  = (ocount_ff == OPEN_CW'(OPEN_DEPTH));
   assign stat.open_empty = (ocount_ff == '0);
   assign stat.vis_full   = (vcount_ff == VIS_CW'(VISITED_DEPTH));
   assign stat.ins_front  = (oidx_ff == '0);
   // equal cost stays in front of the new entry
   assign stat.ins_stop   = (o_rd_cost <= cost_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_out_key  = rsp_key_ff;
   assign rsp_out_cost = rsp_cost_ff;

endmodule

/* rtl/dspq_checker.sv */
// port level checks for the dedup sorted priority queue, bound to the top level
module dspq_checker import dspq_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_status,
   input logic [KEY_W-1:0]  rsp_out_key,
   input logic [COST_W-1:0] rsp_out_cost
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_out_key) && $stable(rsp_out_cost))
      else $error("response changed while stalled");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= 3'(ST_VISITED_FULL))
      else $error("response status out of range");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 3'(ST_POPPED) |-> rsp_out_key == '0 && rsp_out_cost == '0)
      else $error("non-pop response carries a state");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

endmodule

bind dedup_sorted_priority_queue dspq_checker u_dspq_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_out_key  (rsp_out_key),
   .rsp_out_cost (rsp_out_cost)
);
